>>> rtl/eams_pkg.sv
// shared types, constants and helper functions of the edge-avoid motor sequencer
package eams_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int DUTY_W         = 8;
    localparam int DUR_W          = 16;

    localparam logic [DUTY_W-1:0] DRIVE_SPEED_RST       = 8'd230;
    localparam logic [DUTY_W-1:0] LEFT_TRIM_RST         = 8'd7;
    localparam logic [DUTY_W-1:0] RIGHT_TRIM_RST        = 8'd0;
    localparam logic [DUR_W-1:0]  REVERSE_TICKS_RST     = 16'd300;
    localparam logic [DUR_W-1:0]  TURN_TICKS_RST        = 16'd200;
    localparam logic [DUR_W-1:0]  ESCAPE_TURN_TICKS_RST = 16'd300;
    localparam logic [DUR_W-1:0]  POLL_TICKS_RST        = 16'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DRIVE_SPEED       = 3'd0,
        REG_LEFT_TRIM         = 3'd1,
        REG_RIGHT_TRIM        = 3'd2,
        REG_REVERSE_TICKS     = 3'd3,
        REG_TURN_TICKS        = 3'd4,
        REG_ESCAPE_TURN_TICKS = 3'd5,
        REG_POLL_TICKS        = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_SAMPLE,
        PH_REVERSE,
        PH_TURN,
        PH_POLL
    } phase_t;

    typedef enum logic [1:0] {
        TURN_NONE,
        TURN_LEFT,
        TURN_RIGHT,
        TURN_ESCAPE
    } turn_t;

    typedef enum logic [2:0] {
        MODE_STOP,
        MODE_FWD,
        MODE_REV,
        MODE_ROT_L,
        MODE_ROT_R
    } mode_t;

    typedef struct packed {
        logic [DUTY_W-1:0] drive_speed;
        logic [DUTY_W-1:0] left_trim;
        logic [DUTY_W-1:0] right_trim;
        logic [DUR_W-1:0]  reverse_ticks;
        logic [DUR_W-1:0]  turn_ticks;
        logic [DUR_W-1:0]  escape_turn_ticks;
        logic [DUR_W-1:0]  poll_ticks;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_fwd;
        logic [DUTY_W-1:0] left_rev;
        logic [DUTY_W-1:0] right_fwd;
        logic [DUTY_W-1:0] right_rev;
    } duty_t;

    // speed minus trim, clamped at zero
    function automatic logic [DUTY_W-1:0] sat_sub(input logic [DUTY_W-1:0] speed,
                                                  input logic [DUTY_W-1:0] trim);
        return (speed > trim) ? (speed - trim) : '0;
    endfunction

endpackage

>>> rtl/eams_cfg.sv
// configuration register file of the edge-avoid motor sequencer
module eams_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [eams_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [eams_pkg::CFG_DATA_W-1:0]   cfg_data,
    output eams_pkg::cfg_t                    cfg
);
    import eams_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_speed       <= DRIVE_SPEED_RST;
            cfg_reg.left_trim         <= LEFT_TRIM_RST;
            cfg_reg.right_trim        <= RIGHT_TRIM_RST;
            cfg_reg.reverse_ticks     <= REVERSE_TICKS_RST;
            cfg_reg.turn_ticks        <= TURN_TICKS_RST;
            cfg_reg.escape_turn_ticks <= ESCAPE_TURN_TICKS_RST;
            cfg_reg.poll_ticks        <= POLL_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DRIVE_SPEED:       cfg_reg.drive_speed       <= cfg_data[DUTY_W-1:0];
                REG_LEFT_TRIM:         cfg_reg.left_trim         <= cfg_data[DUTY_W-1:0];
                REG_RIGHT_TRIM:        cfg_reg.right_trim        <= cfg_data[DUTY_W-1:0];
                REG_REVERSE_TICKS:     cfg_reg.reverse_ticks     <= cfg_data[DUR_W-1:0];
                REG_TURN_TICKS:        cfg_reg.turn_ticks        <= cfg_data[DUR_W-1:0];
                REG_ESCAPE_TURN_TICKS: cfg_reg.escape_turn_ticks <= cfg_data[DUR_W-1:0];
                REG_POLL_TICKS:        cfg_reg.poll_ticks        <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/eams_core.sv
// manoeuvre state machine and duty selection, one tick per step
module eams_core #(
    parameter int TIMER_BITS = eams_pkg::TIMER_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            left_hit,
    input  logic            right_hit,
    input  logic            coin,
    input  eams_pkg::cfg_t  cfg,
    output eams_pkg::duty_t duty
);
    import eams_pkg::*;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    // duration register to timer load value: zero counts as one, clamp to timer range
    function automatic logic [TIMER_BITS-1:0] load_len(input logic [DUR_W-1:0] v);
        logic [32:0] n;
        n = (v == '0) ? 33'd1 : 33'(v);
        if (n > TIMER_MAX)
            n = TIMER_MAX;
        return n[TIMER_BITS-1:0];
    endfunction

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    turn_t                 turn_reg, turn_next;
    mode_t                 mode_reg, mode_next;
    logic                  moving_reg, moving_next;
    logic                  both_reg, both_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SAMPLE;
            timer_reg  <= '0;
            turn_reg   <= TURN_NONE;
            mode_reg   <= MODE_STOP;
            moving_reg <= 1'b0;
            both_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            turn_reg   <= turn_next;
            mode_reg   <= mode_next;
            moving_reg <= moving_next;
            both_reg   <= both_next;
        end
    end

    always_comb
    begin
        logic [DUTY_W-1:0] ld;
        logic [DUTY_W-1:0] rd;

        phase_next  = phase_reg;
        timer_next  = timer_reg;
        turn_next   = turn_reg;
        mode_next   = mode_reg;
        moving_next = moving_reg;
        both_next   = both_reg;

        // sensor sample starts a new manoeuvre on a hit or a pending escape, else drives forward and polls
        if (phase_reg == PH_SAMPLE)
        begin
            if (left_hit || right_hit)
            begin
                moving_next = 1'b0;
                mode_next   = MODE_REV;
                if (left_hit && right_hit)
                begin
                    turn_next = TURN_NONE;
                    both_next = 1'b1;
                end
                else
                begin
                    turn_next = left_hit ? TURN_RIGHT : TURN_LEFT;
                end
                phase_next = PH_REVERSE;
                timer_next = load_len(cfg.reverse_ticks);
            end
            else if (both_reg)
            begin
                moving_next = 1'b0;
                mode_next   = coin ? MODE_ROT_R : MODE_ROT_L;
                turn_next   = TURN_ESCAPE;
                phase_next  = PH_TURN;
                timer_next  = load_len(cfg.escape_turn_ticks);
            end
            else
            begin
                if (!moving_reg)
                begin
                    mode_next   = MODE_FWD;
                    moving_next = 1'b1;
                end
                phase_next = PH_POLL;
                timer_next = load_len(cfg.poll_ticks);
            end
        end

        // duties of this tick follow the mode after sampling
        ld   = sat_sub(cfg.drive_speed, cfg.left_trim);
        rd   = sat_sub(cfg.drive_speed, cfg.right_trim);
        duty = '0;
        case (mode_next)
            MODE_FWD:
            begin
                duty.left_fwd  = ld;
                duty.right_fwd = rd;
            end
            MODE_REV:
            begin
                duty.left_rev  = ld;
                duty.right_rev = rd;
            end
            MODE_ROT_L:
            begin
                duty.left_rev  = ld;
                duty.right_fwd = rd;
            end
            MODE_ROT_R:
            begin
                duty.left_fwd  = ld;
                duty.right_rev = rd;
            end
            default: ;
        endcase

        // countdown and end-of-phase transitions
        if (timer_next != '0)
            timer_next = timer_next - TIMER_BITS'(1);
        if (timer_next == '0)
        begin
            case (phase_next)
                PH_REVERSE:
                begin
                    if (turn_next == TURN_LEFT || turn_next == TURN_RIGHT)
                    begin
                        mode_next  = (turn_next == TURN_LEFT) ? MODE_ROT_L : MODE_ROT_R;
                        turn_next  = TURN_NONE;
                        phase_next = PH_TURN;
                        timer_next = load_len(cfg.turn_ticks);
                    end
                    else
                    begin
                        mode_next  = MODE_STOP;
                        turn_next  = TURN_NONE;
                        phase_next = PH_POLL;
                        timer_next = load_len(cfg.poll_ticks);
                    end
                end
                PH_TURN:
                begin
                    if (turn_next == TURN_ESCAPE)
                    begin
                        both_next   = 1'b0;
                        mode_next   = MODE_FWD;
                        moving_next = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_STOP;
                    end
                    turn_next  = TURN_NONE;
                    phase_next = PH_POLL;
                    timer_next = load_len(cfg.poll_ticks);
                end
                default:
                begin
                    phase_next = PH_SAMPLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/edge_avoid_motor_sequencer_top.sv
// top level of the edge-avoid motor sequencer: tick pipeline and config port
//
// usage
// - input channel: one request per timebase tick, carrying left_sensor,
//   right_sensor and coin_bit; taken when in_valid is high and in_stall low
// - output channel: one request per tick with the four motor pwm duties;
//   taken when out_valid is high and out_stall low
// - config port: cfg_we writes cfg_data into register cfg_index at the
//   clock edge (0 speed, 1/2 left/right trim, 3..6 durations in ticks);
//   index 7 is ignored; write only while no tick is in flight
// - path: each accepted tick passes the input register, then the sequencer
//   logic into the output register, before its duties reach the output
// - throughput: one tick per cycle, limited only by out_stall
// - stall: a full output register holds while out_stall is high; an empty
//   input register still takes one more tick, after which in_stall rises
// - reset: async, active low; sequencer restarts in its sample phase with
//   motors stopped, config registers back to their defaults
module edge_avoid_motor_sequencer_top #(
    parameter int TIMER_BITS = eams_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              left_sensor,
    input  logic                              right_sensor,
    input  logic                              coin_bit,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [eams_pkg::DUTY_W-1:0]       left_fwd_duty,
    output logic [eams_pkg::DUTY_W-1:0]       left_rev_duty,
    output logic [eams_pkg::DUTY_W-1:0]       right_fwd_duty,
    output logic [eams_pkg::DUTY_W-1:0]       right_rev_duty,
    input  logic                              cfg_we,
    input  logic [eams_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [eams_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import eams_pkg::*;

    cfg_t  cfg;
    duty_t duty;

    // input stage
    logic  s1_valid_reg;
    logic  s1_left_reg;
    logic  s1_right_reg;
    logic  s1_coin_reg;

    // output stage
    logic  out_valid_reg;
    duty_t out_duty_reg;

    logic  out_load;
    logic  step;
    logic  in_take;

    // output register can take a new result when empty or being drained
    assign out_load = !out_valid_reg || !out_stall;
    // the pending tick advances through the sequencer
    assign step     = s1_valid_reg && out_load;
    // input register frees up when empty or when its tick advances
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    eams_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    eams_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .left_hit   (s1_left_reg),
        .right_hit  (s1_right_reg),
        .coin       (s1_coin_reg),
        .cfg        (cfg),
        .duty       (duty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // sensor payload, captured with each accepted tick
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_left_reg  <= left_sensor;
            s1_right_reg <= right_sensor;
            s1_coin_reg  <= coin_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_duty_reg <= duty;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_fwd_duty  = out_duty_reg.left_fwd;
    assign left_rev_duty  = out_duty_reg.left_rev;
    assign right_fwd_duty = out_duty_reg.right_fwd;
    assign right_rev_duty = out_duty_reg.right_rev;

`ifndef SYNTHESIS
    // back-pressure only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    // a tick held in the input stage is never dropped
    a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && in_stall) |=> s1_valid_reg)
        else $error("held tick lost from input stage");

    // a motor is never driven forward and backward at once
    a_left_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_fwd_duty == '0 || left_rev_duty == '0))
        else $error("left motor driven both ways");

    a_right_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_fwd_duty == '0 || right_rev_duty == '0))
        else $error("right motor driven both ways");
`endif

endmodule
